### hdl/cqrp_pkg.sv
`default_nettype none

package cqrp_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 64;
    localparam int ENTRY_BYTES = 64;

    // One lane per 64-bit word of an entry.
    localparam int WORD_W      = 64;
    localparam int NUM_LANES   = 8;
    localparam int LANE_W      = 3;
    localparam int ENTRY_WORDS = (ENTRY_BYTES + 7) / 8;

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Field widths.
    localparam int MODE_W = 2;
    localparam int SIZE_W = 7;
    localparam int OCC_W  = 7;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] read_size;
        logic              entry_short;
        logic [WORD_W-1:0] entry_word0;
        logic [WORD_W-1:0] entry_word1;
        logic [WORD_W-1:0] entry_word2;
        logic [WORD_W-1:0] entry_word3;
        logic [WORD_W-1:0] entry_word4;
        logic [WORD_W-1:0] entry_word5;
        logic [WORD_W-1:0] entry_word6;
        logic [WORD_W-1:0] entry_word7;
    } t_cq_in;

    typedef struct packed {
        logic [WORD_W-1:0] data_word0;
        logic [WORD_W-1:0] data_word1;
        logic [WORD_W-1:0] data_word2;
        logic [WORD_W-1:0] data_word3;
        logic [WORD_W-1:0] data_word4;
        logic [WORD_W-1:0] data_word5;
        logic [WORD_W-1:0] data_word6;
        logic [WORD_W-1:0] data_word7;
        logic              entry_returned;
        logic [OCC_W-1:0]  occupancy;
        logic              irq_level;
    } t_cq_out;

    // Per-request control from the pointer logic to the lanes and merge stage.
    typedef struct packed {
        logic              mem_we;
        logic              mem_re;
        logic              wr_zero;
        logic [ADDR_W-1:0] addr;
        logic              returned;
        logic [SIZE_W-1:0] limit;
        logic [OCC_W-1:0]  occupancy;
        logic              irq_level;
    } t_cq_ctl;

endpackage

`default_nettype wire

### hdl/cqrp_lane.sv
`default_nettype none

module cqrp_lane
    import cqrp_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_we,
    input  wire               i_re,
    input  wire               i_wr_zero,
    input  wire  [ADDR_W-1:0] i_addr,
    input  wire  [WORD_W-1:0] i_wdata,
    input  wire  [LANE_W-1:0] i_lane,
    input  wire  [SIZE_W-1:0] i_limit,
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_mem [QUEUE_DEPTH];
    logic [WORD_W-1:0] r_rdata;
    logic              lane_unused;

    // Words past the configured entry size are always stored as zero.
    assign lane_unused = ({1'b0, i_lane} >= (LANE_W + 1)'(ENTRY_WORDS));

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= (i_wr_zero || lane_unused) ? '0 : i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    // Keep only the bytes that fall below the read limit.
    always_comb begin
        logic [7:0] pos;
        for (int b = 0; b < 8; b++) begin
            pos = 8'({i_lane, 3'(b)});
            o_word[b*8 +: 8] = (pos < 8'(i_limit)) ? r_rdata[b*8 +: 8] : 8'd0;
        end
    end

endmodule

`default_nettype wire

### hdl/cqrp_ctrl.sv
`default_nettype none

module cqrp_ctrl
    import cqrp_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_cfg_we,
    input  wire     i_cfg_wdata,
    input  wire     i_acc,
    input  t_cq_in  i_item,
    output t_cq_ctl o_ctl
);

    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_irq, n_irq;
    logic              r_irq_en;
    logic [ADDR_W:0]   tail_sum;
    logic [ADDR_W-1:0] tail;
    logic [ADDR_W-1:0] head_inc;

    assign tail_sum = {1'b0, r_head} + (ADDR_W + 1)'(r_count);
    assign tail     = (tail_sum >= (ADDR_W + 1)'(QUEUE_DEPTH))
                    ? ADDR_W'(tail_sum - (ADDR_W + 1)'(QUEUE_DEPTH))
                    : ADDR_W'(tail_sum);
    assign head_inc = (r_head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + ADDR_W'(1);

    always_comb begin
        n_head          = r_head;
        n_count         = r_count;
        n_irq           = r_irq;
        o_ctl           = '0;
        o_ctl.addr      = r_head;
        unique case (i_item.mode)
            MODE_PUSH: begin
                o_ctl.mem_we  = i_acc;
                o_ctl.wr_zero = i_item.entry_short;
                o_ctl.addr    = tail;
                if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                    n_head = head_inc;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
                if (r_irq_en) begin
                    n_irq = 1'b1;
                end
            end
            MODE_READ: begin
                if (r_count != '0) begin
                    o_ctl.mem_re   = i_acc;
                    o_ctl.returned = 1'b1;
                    o_ctl.limit    = (i_item.read_size > SIZE_W'(ENTRY_BYTES))
                                   ? SIZE_W'(ENTRY_BYTES) : i_item.read_size;
                    n_head  = head_inc;
                    n_count = r_count - CNT_W'(1);
                    if (r_irq_en && (n_count == '0)) begin
                        n_irq = 1'b0;
                    end
                end
            end
            MODE_WRITE: begin
            end
            default: begin
            end
        endcase
        o_ctl.occupancy = OCC_W'(n_count);
        o_ctl.irq_level = r_irq_en & n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_irq    <= 1'b0;
            r_irq_en <= 1'b1;
        end else begin
            if (i_acc) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_irq   <= n_irq;
            end
            if (i_cfg_we) begin
                r_irq_en <= i_cfg_wdata;
            end
        end
    end

`ifndef SYNTHESIS
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && (i_item.mode == MODE_PUSH) && (r_count < CNT_W'(QUEUE_DEPTH)))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push into a non-full queue did not add an entry");

    a_read_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && (i_item.mode == MODE_READ) && (r_count != '0))
        |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("read of a non-empty queue did not remove an entry");

    a_irq_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && (i_item.mode == MODE_READ) && (r_count == CNT_W'(1)) && r_irq_en)
        |=> !r_irq)
        else $error("interrupt still set after the last entry was popped");

    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.returned || o_ctl.mem_re) |-> (r_count != '0))
        else $error("pop issued on an empty queue");
`endif

endmodule

`default_nettype wire

### hdl/cqrp_merge.sv
`default_nettype none

module cqrp_merge
    import cqrp_pkg::*;
(
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_acc,
    input  t_cq_ctl                          i_ctl,
    input  wire  [NUM_LANES-1:0][WORD_W-1:0] i_lane_word,
    input  wire                              i_out_stall,
    output logic [SIZE_W-1:0]                o_limit,
    output logic                             o_s1_free,
    output logic                             o_out_valid,
    output t_cq_out                          o_out_data
);

    logic              r_s1_vld;
    logic              r_s1_returned;
    logic [SIZE_W-1:0] r_s1_limit;
    logic [OCC_W-1:0]  r_s1_occ;
    logic              r_s1_irq;
    logic              r_o_vld;
    t_cq_out           r_out, n_out;
    logic              out_take;
    logic              s1_move;

    assign out_take  = !r_o_vld || !i_out_stall;
    assign s1_move   = r_s1_vld && out_take;
    assign o_s1_free = !r_s1_vld || out_take;
    assign o_limit   = r_s1_limit;

    always_comb begin
        n_out                = '0;
        n_out.data_word0     = i_lane_word[0];
        n_out.data_word1     = i_lane_word[1];
        n_out.data_word2     = i_lane_word[2];
        n_out.data_word3     = i_lane_word[3];
        n_out.data_word4     = i_lane_word[4];
        n_out.data_word5     = i_lane_word[5];
        n_out.data_word6     = i_lane_word[6];
        n_out.data_word7     = i_lane_word[7];
        n_out.entry_returned = r_s1_returned;
        n_out.occupancy      = r_s1_occ;
        n_out.irq_level      = r_s1_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (i_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_o_vld <= 1'b1;
            end else if (out_take) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1_returned <= i_ctl.returned;
            r_s1_limit    <= i_ctl.limit;
            r_s1_occ      <= i_ctl.occupancy;
            r_s1_irq      <= i_ctl.irq_level;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### hdl/completion_queue_read_port.sv
`default_nettype none

// Channel   Direction  Handshake                     Payload
// request   in         i_in_valid / o_in_stall       i_in_data  (t_cq_in)
// result    out        o_out_valid / i_out_stall     o_out_data (t_cq_out)
// config    in         i_cfg_we                      i_cfg_wdata (irq_enable)
//
// One request is taken per cycle while o_in_stall is low, and its result
// is held in the first stage, then in the output register. Each lane has
// a 64-word RAM used at most once per request. Pointers update on accept.
// Reset is synchronous and active low; it clears the pointers, the count and
// the interrupt line, and sets irq_enable. The entry RAM is not cleared.
// A stalled result holds the output register; the stage behind it still
// takes one more request before the input stalls.

module completion_queue_read_port
    import cqrp_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_cfg_we,
    input  wire     i_cfg_wdata,
    input  wire     i_in_valid,
    output logic    o_in_stall,
    input  t_cq_in  i_in_data,
    output logic    o_out_valid,
    input  wire     i_out_stall,
    output t_cq_out o_out_data
);

    logic                             acc;
    logic                             s1_free;
    t_cq_ctl                          ctl;
    logic [SIZE_W-1:0]                s1_limit;
    logic [NUM_LANES-1:0][WORD_W-1:0] in_word;
    logic [NUM_LANES-1:0][WORD_W-1:0] lane_word;

    // A request is accepted whenever the first pipeline stage is empty or is
    // moving into the output register in the same cycle.
    assign o_in_stall = !s1_free;
    assign acc        = i_in_valid && s1_free;

    // The pushed entry arrives as eight words, one per lane.
    assign in_word[0] = i_in_data.entry_word0;
    assign in_word[1] = i_in_data.entry_word1;
    assign in_word[2] = i_in_data.entry_word2;
    assign in_word[3] = i_in_data.entry_word3;
    assign in_word[4] = i_in_data.entry_word4;
    assign in_word[5] = i_in_data.entry_word5;
    assign in_word[6] = i_in_data.entry_word6;
    assign in_word[7] = i_in_data.entry_word7;

    // Head, count and interrupt state. A push writes at the tail, dropping the
    // oldest entry when the queue is full; a read pops the head.
    cqrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (acc),
        .i_item      (i_in_data),
        .o_ctl       (ctl)
    );

    // Each lane stores one word of every entry and masks its read word by the
    // byte limit of the request in the first stage.
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        cqrp_lane u_lane (
            .i_clk     (i_clk),
            .i_we      (ctl.mem_we),
            .i_re      (ctl.mem_re),
            .i_wr_zero (ctl.wr_zero),
            .i_addr    (ctl.addr),
            .i_wdata   (in_word[g]),
            .i_lane    (LANE_W'(g)),
            .i_limit   (s1_limit),
            .o_word    (lane_word[g])
        );
    end

    // The merge stage gathers the lane words with the status of the request
    // and holds the finished result until the consumer takes it.
    cqrp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_ctl       (ctl),
        .i_lane_word (lane_word),
        .i_out_stall (i_out_stall),
        .o_limit     (s1_limit),
        .o_s1_free   (s1_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
